// ----- rtl/kvt_pkg.sv -----
// Shared types, request codes and default sizes for the key/value table.
package kvt_pkg;

  localparam int KIND_W      = 2;
  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd3;

  typedef struct packed {
    logic                    is_insert;
    logic                    is_lookup;
    logic                    is_delete;
    logic                    is_dump;
    logic signed [KEY_W-1:0] key;
    logic [DATA_W-1:0]       value;
  } req_t;

  typedef struct packed {
    logic                    strobe;
    logic                    ok;
    logic                    found;
    logic signed [KEY_W-1:0] key;
    logic [DATA_W-1:0]       value;
    logic                    entry_valid;
    logic                    last;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- rtl/kvt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/kvt_front.sv -----
// Request front end: takes a command, decodes its kind and hands it to the queue.
module kvt_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [kvt_pkg::KIND_W-1:0]          kind,
  input  logic signed [kvt_pkg::KEY_W-1:0]    key,
  input  logic [kvt_pkg::DATA_W-1:0]          value_in,
  input  logic                                q_full,
  output logic                                busy,
  output logic                                push,
  output kvt_pkg::req_t                       push_req
);

  logic          held;
  kvt_pkg::req_t req;
  kvt_pkg::req_t req_next;
  logic          accept;

  assign push     = held && !q_full;
  assign busy     = held && q_full;
  assign accept   = start && !busy;
  assign push_req = req;

  always_comb begin
    req_next           = '0;
    req_next.key       = key;
    case (kind)
      kvt_pkg::KIND_INSERT: begin
        req_next.is_insert = 1'b1;
        req_next.value     = value_in;
      end
      kvt_pkg::KIND_LOOKUP: req_next.is_lookup = 1'b1;
      kvt_pkg::KIND_DELETE: req_next.is_delete = 1'b1;
      kvt_pkg::KIND_DUMP:   req_next.is_dump   = 1'b1;
      default:              req_next.is_lookup = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
      req  <= req_next;
    end else if (push) begin
      held <= 1'b0;
    end
  end

endmodule

// ----- rtl/kvt_queue.sv -----
// Short request queue between the front end and the table engine.
module kvt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  kvt_pkg::req_t       push_req,
  input  logic                pop,
  output kvt_pkg::req_t       head,
  output kvt_pkg::q_status_t  status
);

  localparam int PTR_W = (kvt_pkg::QUEUE_DEPTH > 1) ? $clog2(kvt_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(kvt_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(kvt_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(kvt_pkg::QUEUE_DEPTH);

  kvt_pkg::req_t    slots [kvt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (fill == FULL_CNT);
  assign status.empty = (fill == '0);
  assign head         = slots[rd_ptr];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/kvt_back.sv -----
// Table engine: parallel key match for insert/lookup/delete, ordered scan for dump.
module kvt_back #(
  parameter int CAPACITY    = kvt_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = kvt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  kvt_pkg::req_t       head,
  input  kvt_pkg::q_status_t  q_status,
  output logic                pop,
  output kvt_pkg::res_t       res
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_RESP  = 3'd3;
  localparam logic [2:0] S_DINIT = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]                       state;
  kvt_pkg::req_t                    req;
  logic [CAPACITY-1:0]              used;
  logic signed [kvt_pkg::KEY_W-1:0] cell_key [CAPACITY];
  logic [CNT_W-1:0]                 count;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             has_free;
  logic [IDX_W-1:0] free_idx;

  logic [IDX_W-1:0]                 scan_idx;
  logic                             pend;
  logic [IDX_W-1:0]                 pend_idx;
  logic                             best_found;
  logic signed [kvt_pkg::KEY_W-1:0] best_key;
  logic [VALUE_WIDTH-1:0]           best_value;
  logic                             have_prev;
  logic signed [kvt_pkg::KEY_W-1:0] prev_key;
  logic [CNT_W-1:0]                 remaining;

  logic [CAPACITY-1:0] match;
  logic                hit_c;
  logic [IDX_W-1:0]    hit_idx_c;
  logic                free_c;
  logic [IDX_W-1:0]    free_idx_c;

  logic                             vram_we;
  logic [IDX_W-1:0]                 vram_waddr;
  logic [IDX_W-1:0]                 vram_raddr;
  logic [VALUE_WIDTH-1:0]           vram_rdata;
  logic                             kram_we;
  logic [kvt_pkg::KEY_W-1:0]        kram_rdata;
  logic signed [kvt_pkg::KEY_W-1:0] scan_key;
  logic                             cand;

  // Keys are unique, so at most one match bit is set and an OR encoder suffices.
  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = used[i] && (cell_key[i] == req.key);
      if (match[i]) begin
        hit_c     = 1'b1;
        hit_idx_c = hit_idx_c | IDX_W'(i);
      end
    end
  end

  // Walk downward so the lowest free slot wins.
  always_comb begin
    free_c     = 1'b0;
    free_idx_c = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_c     = 1'b1;
        free_idx_c = IDX_W'(i);
      end
    end
  end

  assign pop        = (state == S_IDLE) && !q_status.empty;
  assign vram_we    = (state == S_RESP) && req.is_insert && (hit || has_free);
  assign vram_waddr = hit ? hit_idx : free_idx;
  assign vram_raddr = (state == S_SCAN) ? scan_idx : hit_idx;
  assign kram_we    = (state == S_RESP) && req.is_insert && !hit && has_free;
  assign scan_key   = $signed(kram_rdata);

  // Keep the smallest key above the one emitted last.
  assign cand = pend && used[pend_idx] &&
                (!have_prev || (scan_key > prev_key)) &&
                (!best_found || (scan_key < best_key));

  kvt_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (VALUE_WIDTH'(req.value)),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  kvt_ram #(
    .WIDTH (kvt_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (kram_we),
    .waddr (free_idx),
    .wdata (req.key),
    .raddr (scan_idx),
    .rdata (kram_rdata)
  );

  always_ff @(posedge clk) begin
    if (kram_we) begin
      cell_key[free_idx] <= req.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      count      <= '0;
      pend       <= 1'b0;
      res.strobe <= 1'b0;
    end else begin
      res.strobe <= 1'b0;
      pend       <= (state == S_SCAN);
      pend_idx   <= scan_idx;
      if (cand) begin
        best_found <= 1'b1;
        best_key   <= scan_key;
        best_value <= vram_rdata;
      end
      case (state)
        S_IDLE: begin
          if (!q_status.empty) begin
            req   <= head;
            state <= head.is_dump ? S_DINIT : S_MATCH;
          end
        end
        S_MATCH: begin
          hit      <= hit_c;
          hit_idx  <= hit_idx_c;
          has_free <= free_c;
          free_idx <= free_idx_c;
          state    <= S_READ;
        end
        S_READ: begin
          state <= S_RESP;
        end
        S_RESP: begin
          res.strobe      <= 1'b1;
          res.ok          <= 1'b1;
          res.found       <= hit;
          res.key         <= req.key;
          res.value       <= hit ? kvt_pkg::DATA_W'(vram_rdata) : '0;
          res.entry_valid <= 1'b1;
          res.last        <= 1'b1;
          if (req.is_insert && !hit) begin
            if (has_free) begin
              used[free_idx] <= 1'b1;
              count          <= count + 1'b1;
            end else begin
              res.ok <= 1'b0;
            end
          end
          if (req.is_delete && hit) begin
            used[hit_idx] <= 1'b0;
            count         <= count - 1'b1;
          end
          state <= S_IDLE;
        end
        S_DINIT: begin
          if (count == '0) begin
            res.strobe      <= 1'b1;
            res.ok          <= 1'b1;
            res.found       <= 1'b0;
            res.key         <= req.key;
            res.value       <= '0;
            res.entry_valid <= 1'b0;
            res.last        <= 1'b1;
            state           <= S_IDLE;
          end else begin
            remaining  <= count;
            have_prev  <= 1'b0;
            best_found <= 1'b0;
            scan_idx   <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_idx == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          // consume the read of the final slot
          state <= S_EMIT;
        end
        S_EMIT: begin
          res.strobe      <= 1'b1;
          res.ok          <= 1'b1;
          res.found       <= 1'b1;
          res.key         <= best_key;
          res.value       <= kvt_pkg::DATA_W'(best_value);
          res.entry_valid <= 1'b1;
          res.last        <= (remaining == ONE_CNT);
          prev_key        <= best_key;
          have_prev       <= 1'b1;
          best_found      <= 1'b0;
          remaining       <= remaining - 1'b1;
          scan_idx        <= '0;
          state           <= (remaining == ONE_CNT) ? S_IDLE : S_SCAN;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/key_value_table_core.sv -----
// Top level of the key/value table: front end, request queue and table engine.
//
//   channel   direction  transfer when        fields
//   request   in         start && !busy      kind, key, value_in
//   result    out        strobe (one cycle)  ok, found, key_out, value_out, entry_valid, last
//
// Insert, lookup and delete pass the engine states queue pop, key match, value
// RAM read and response, after the front end has registered the request.
// A dump makes each result from one full pass over the key RAM, one slot a cycle.
// rst is synchronous; it clears the used marks, entry count, queue and state registers.
// Results cannot be held off; busy rises only while the queue is full and the
// front end holds a request.
module key_value_table_core #(
  parameter int CAPACITY    = kvt_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = kvt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [kvt_pkg::KIND_W-1:0]       kind,
  input  logic signed [kvt_pkg::KEY_W-1:0] key,
  input  logic [kvt_pkg::DATA_W-1:0]       value_in,
  output logic                             strobe,
  output logic                             ok,
  output logic                             found,
  output logic signed [kvt_pkg::KEY_W-1:0] key_out,
  output logic [kvt_pkg::DATA_W-1:0]       value_out,
  output logic                             entry_valid,
  output logic                             last
);

  logic               push;
  kvt_pkg::req_t      push_req;
  logic               pop;
  kvt_pkg::req_t      head;
  kvt_pkg::q_status_t q_status;
  kvt_pkg::res_t      res;

  kvt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .kind     (kind),
    .key      (key),
    .value_in (value_in),
    .q_full   (q_status.full),
    .busy     (busy),
    .push     (push),
    .push_req (push_req)
  );

  kvt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  kvt_back #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .res      (res)
  );

  assign strobe      = res.strobe;
  assign ok          = res.ok;
  assign found       = res.found;
  assign key_out     = res.key;
  assign value_out   = res.value;
  assign entry_valid = res.entry_valid;
  assign last        = res.last;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("result strobe right after reset");

  a_busy_queue: assert property (@(posedge clk) disable iff (rst)
    busy |-> q_status.full)
    else $error("busy while the request queue has room");

  a_empty_dump: assert property (@(posedge clk) disable iff (rst)
    (strobe && !entry_valid) |-> (last && ok && !found))
    else $error("empty dump result is malformed");

  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (strobe && !ok) |-> (last && !found && entry_valid))
    else $error("failed insert result is malformed");

  a_dump_spacing: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> !strobe)
    else $error("dump results back to back");

endmodule

// ----- tb/key_value_table_checker.sv -----
// Checker for the key/value table: tracks requests, predicts the table, compares results.
`timescale 1ns / 100ps
module key_value_table_checker #(
  parameter int CAPACITY = kvt_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [kvt_pkg::KIND_W-1:0]       kind,
  input  logic signed [kvt_pkg::KEY_W-1:0] key,
  input  logic [kvt_pkg::DATA_W-1:0]       value_in,
  input  logic                             strobe,
  input  logic                             ok,
  input  logic                             found,
  input  logic signed [kvt_pkg::KEY_W-1:0] key_out,
  input  logic [kvt_pkg::DATA_W-1:0]       value_out,
  input  logic                             entry_valid,
  input  logic                             last,
  output int                               failures,
  output int                               outstanding
);

  typedef struct packed {
    logic                             ok;
    logic                             found;
    logic signed [kvt_pkg::KEY_W-1:0] key;
    logic [kvt_pkg::DATA_W-1:0]       value;
    logic                             entry_valid;
    logic                             last;
  } reply_t;

  logic                             slot_used  [CAPACITY];
  logic signed [kvt_pkg::KEY_W-1:0] slot_key   [CAPACITY];
  logic [kvt_pkg::DATA_W-1:0]       slot_value [CAPACITY];
  reply_t                           awaited_replies [$];

  // Update the table copy for one accepted request and queue the replies it causes.
  task automatic apply_request(input logic [kvt_pkg::KIND_W-1:0] op,
                               input logic signed [kvt_pkg::KEY_W-1:0] k,
                               input logic [kvt_pkg::DATA_W-1:0] v);
    int                  hit;
    int                  free;
    int                  best;
    int                  count;
    logic [CAPACITY-1:0] emitted;
    hit = -1;
    free = -1;
    count = 0;
    emitted = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_used[i] && slot_key[i] == k && hit < 0) hit = i;
      if (!slot_used[i] && free < 0) free = i;
      if (slot_used[i]) count++;
    end
    case (op)
      kvt_pkg::KIND_INSERT: begin
        if (hit >= 0) begin
          awaited_replies.push_back(reply_t'{1'b1, 1'b1, k, slot_value[hit], 1'b1, 1'b1});
          slot_value[hit] = v;
        end else if (free >= 0) begin
          slot_used[free] = 1'b1;
          slot_key[free] = k;
          slot_value[free] = v;
          awaited_replies.push_back(reply_t'{1'b1, 1'b0, k, '0, 1'b1, 1'b1});
        end else begin
          awaited_replies.push_back(reply_t'{1'b0, 1'b0, k, '0, 1'b1, 1'b1});
        end
      end
      kvt_pkg::KIND_LOOKUP, kvt_pkg::KIND_DELETE: begin
        if (hit >= 0) begin
          awaited_replies.push_back(reply_t'{1'b1, 1'b1, k, slot_value[hit], 1'b1, 1'b1});
          if (op == kvt_pkg::KIND_DELETE) slot_used[hit] = 1'b0;
        end else begin
          awaited_replies.push_back(reply_t'{1'b1, 1'b0, k, '0, 1'b1, 1'b1});
        end
      end
      kvt_pkg::KIND_DUMP: begin
        if (count == 0) begin
          awaited_replies.push_back(reply_t'{1'b1, 1'b0, k, '0, 1'b0, 1'b1});
        end else begin
          // Select the smallest signed key not yet emitted, once per entry.
          for (int n = 0; n < count; n++) begin
            best = -1;
            for (int i = 0; i < CAPACITY; i++) begin
              if (slot_used[i] && !emitted[i]) begin
                if (best < 0) best = i;
                else if (slot_key[i] < slot_key[best]) best = i;
              end
            end
            emitted[best] = 1'b1;
            awaited_replies.push_back(reply_t'{1'b1, 1'b1, slot_key[best], slot_value[best],
                                               1'b1, (n == count - 1)});
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) slot_used[i] = 1'b0;
      awaited_replies.delete();
      failures = 0;
    end else begin
      if (strobe) begin
        got = '{ok, found, key_out, value_out, entry_valid, last};
        if (awaited_replies.size() == 0) begin
          failures++;
          $display("%0t: unexpected result: ok=%b found=%b key=%0d value=%h valid=%b last=%b",
                   $realtime, got.ok, got.found, got.key, got.value, got.entry_valid, got.last);
        end else begin
          want = awaited_replies.pop_front();
          if (got !== want) begin
            failures++;
            $display("%0t: mismatch: expected ok=%b found=%b key=%0d value=%h valid=%b last=%b",
                     $realtime, want.ok, want.found, want.key, want.value, want.entry_valid,
                     want.last);
            $display("%0t:           actual ok=%b found=%b key=%0d value=%h valid=%b last=%b",
                     $realtime, got.ok, got.found, got.key, got.value, got.entry_valid,
                     got.last);
          end
        end
      end
      if (start && !busy) apply_request(kind, key, value_in);
    end
    outstanding = awaited_replies.size();
  end

endmodule

// ----- tb/tb_key_value_table_core.sv -----
// Testbench top for the key/value table: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module tb_key_value_table_core;

  localparam int POOL_SIZE    = 24;
  localparam int DRAIN_CYCLES = 400;

  logic                             clk      = 1'b0;
  logic                             rst      = 1'b1;
  logic                             start    = 1'b0;
  logic [kvt_pkg::KIND_W-1:0]       kind     = kvt_pkg::KIND_INSERT;
  logic signed [kvt_pkg::KEY_W-1:0] key      = '0;
  logic [kvt_pkg::DATA_W-1:0]       value_in = '0;
  logic                             busy;
  logic                             strobe;
  logic                             ok;
  logic                             found;
  logic signed [kvt_pkg::KEY_W-1:0] key_out;
  logic [kvt_pkg::DATA_W-1:0]       value_out;
  logic                             entry_valid;
  logic                             last;
  int                               failures;
  int                               outstanding;

  // Keys drawn for most requests, so that hits, replaces and a full table all happen.
  logic signed [kvt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  key_value_table_core uut (.*);

  key_value_table_checker kvt_check (.*);

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // Present one request and hold it until the transfer.
  task automatic issue(input logic [kvt_pkg::KIND_W-1:0] op,
                       input logic signed [kvt_pkg::KEY_W-1:0] k,
                       input logic [kvt_pkg::DATA_W-1:0] v);
    @(negedge clk);
    start <= 1'b1;
    kind <= op;
    key <= k;
    value_in <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for some cycles and scramble the ignored fields.
  task automatic idle_for(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
      kind <= kvt_pkg::KIND_W'($urandom);
      key <= $urandom;
      value_in <= $urandom;
    end
  endtask

  task automatic wait_for_drain();
    do @(negedge clk); while (outstanding != 0);
  endtask

  function automatic logic [kvt_pkg::DATA_W-1:0] random_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [kvt_pkg::KEY_W-1:0] random_key();
    if ($urandom_range(9) < 7) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [kvt_pkg::KIND_W-1:0] random_kind();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return kvt_pkg::KIND_INSERT;
    if (roll < 65) return kvt_pkg::KIND_LOOKUP;
    if (roll < 92) return kvt_pkg::KIND_DELETE;
    return kvt_pkg::KIND_DUMP;
  endfunction

  task automatic run_phase(input int count, input int idle_pct);
    repeat (count) begin
      issue(random_kind(), random_key(), random_value());
      while ($urandom_range(99) < idle_pct) idle_for(1);
    end
    idle_for(1);
    wait_for_drain();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7FFF_FFFF;
    key_pool[2] = -32'sd1;
    key_pool[3] = 32'sd0;
    for (int i = 1; i <= 13; i++) key_pool[3 + i] = i * 32'h1111_1111;
    for (int i = 17; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Empty table, extreme keys and values, replace, then fill past capacity.
    issue(kvt_pkg::KIND_DUMP, 32'sd5, '0);
    issue(kvt_pkg::KIND_LOOKUP, key_pool[0], '1);
    issue(kvt_pkg::KIND_DELETE, key_pool[1], '1);
    issue(kvt_pkg::KIND_INSERT, key_pool[0], '0);
    issue(kvt_pkg::KIND_INSERT, key_pool[1], '1);
    issue(kvt_pkg::KIND_INSERT, key_pool[3], 32'h1234_5678);
    issue(kvt_pkg::KIND_INSERT, key_pool[2], 32'hA5A5_5A5A);
    issue(kvt_pkg::KIND_INSERT, key_pool[1], 32'h5A5A_A5A5);
    issue(kvt_pkg::KIND_LOOKUP, key_pool[0], '0);
    issue(kvt_pkg::KIND_DUMP, 32'sd0, '0);
    issue(kvt_pkg::KIND_DELETE, key_pool[3], '0);
    for (int i = 4; i <= 16; i++) issue(kvt_pkg::KIND_INSERT, key_pool[i], $urandom);
    issue(kvt_pkg::KIND_INSERT, 32'sh0000_1234, $urandom);
    issue(kvt_pkg::KIND_INSERT, key_pool[2], '1);
    issue(kvt_pkg::KIND_DUMP, 32'sh7FFF_FFFF, '1);
    idle_for(1);
    wait_for_drain();

    run_phase(112, 0);
    run_phase(112, 80);
    run_phase(112, 15);
    run_phase(112, 0);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0 && outstanding == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- key_value_table_core.f -----
rtl/kvt_pkg.sv
rtl/kvt_ram.sv
rtl/kvt_front.sv
rtl/kvt_queue.sv
rtl/kvt_back.sv
rtl/key_value_table_core.sv
tb/key_value_table_checker.sv
tb/tb_key_value_table_core.sv
